[design/dpbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpbf_pkg
// shared types and constants of the packet bit framer: item, result and
// command structs, queue sizing and the serialiser phase codes
// ----------------------------------------------------------------------------
package dpbf_pkg;

    localparam int unsigned PRE_W        = 5;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PRE_W-1:0] PRE_RESET = 5'd16;
    // separator bit sits at count eight, data bits below it
    localparam logic [CNT_W-1:0] SEP_CNT   = 5'd8;

    // input request
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // result request
    typedef struct packed {
        logic line_bit;
        logic end_of_packet;
    } t_out_item;

    // classified byte passed from front to back
    typedef struct packed {
        logic              first;
        logic [PRE_W-1:0]  pre_ones;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [BYTE_W-1:0] chk;
    } t_cmd;

    // serialiser phase, one-hot
    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_BYTE = 3'b010,
        PH_CHK  = 3'b100
    } t_phase;

endpackage
`default_nettype wire

[design/dpbf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpbf_front
// accepts data bytes, tracks packet start and the running checksum, and
// writes one command per byte into the queue
// ----------------------------------------------------------------------------
module dpbf_front import dpbf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [PRE_W-1:0] i_cfg_data,
    input  wire logic             i_accept,
    input  wire t_in_item         i_item,
    output t_cmd                  o_cmd
);

    logic [PRE_W-1:0]  r_pre_ones;
    logic              r_inside;
    logic [BYTE_W-1:0] r_chk;
    logic [BYTE_W-1:0] n_chk_sum;

    // checksum restarts at the first byte of a packet
    assign n_chk_sum = (r_inside ? r_chk : '0) ^ i_item.data_byte;

    always_comb begin
        o_cmd.first    = ~r_inside;
        o_cmd.pre_ones = r_pre_ones;
        o_cmd.data     = i_item.data_byte;
        o_cmd.last     = i_item.last_byte;
        o_cmd.chk      = n_chk_sum;
    end

    // preamble length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ones <= PRE_RESET;
        end else if (i_cfg_valid) begin
            r_pre_ones <= i_cfg_data;
        end
    end

    // packet tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_chk    <= '0;
        end else if (i_accept) begin
            r_inside <= ~i_item.last_byte;
            r_chk    <= i_item.last_byte ? '0 : n_chk_sum;
        end
    end

endmodule
`default_nettype wire

[design/dpbf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpbf_queue
// short command queue decoupling the byte front from the bit serialiser
// ----------------------------------------------------------------------------
module dpbf_queue import dpbf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_wr_cmd,
    input  wire logic i_rd,
    output t_cmd      o_rd_cmd,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[design/dpbf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpbf_back
// bit serialiser: walks preamble (first byte), framed byte and framed checksum
// (last byte), one line bit per unstalled cycle into a registered output stage
// ----------------------------------------------------------------------------
module dpbf_back import dpbf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_q_empty,
    output logic      o_q_rd,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    t_cmd             r_cmd;
    logic             r_busy;
    t_phase           r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             advance;
    logic             step;
    logic             finishing;
    logic             load;
    logic             bit_val;
    logic             bit_eop;
    t_phase           n_phase;
    logic [CNT_W-1:0] n_cnt;

    // output stage moves when empty or being taken
    assign advance = ~r_out_valid | i_pop;
    assign step    = advance & r_busy;

    // current bit and next position
    always_comb begin
        bit_val   = 1'b0;
        bit_eop   = 1'b0;
        finishing = 1'b0;
        n_phase   = r_phase;
        n_cnt     = r_cnt - 1'b1;
        case (r_phase)
            PH_PRE: begin
                bit_val = 1'b1;
                if (r_cnt == '0) begin
                    n_phase = PH_BYTE;
                    n_cnt   = SEP_CNT;
                end
            end
            PH_BYTE: begin
                bit_val = (r_cnt == SEP_CNT) ? 1'b0 : r_cmd.data[r_cnt[2:0]];
                if (r_cnt == '0) begin
                    if (r_cmd.last) begin
                        n_phase = PH_CHK;
                        n_cnt   = SEP_CNT;
                    end else begin
                        finishing = 1'b1;
                    end
                end
            end
            PH_CHK: begin
                bit_val = (r_cnt == SEP_CNT) ? 1'b0 : r_cmd.chk[r_cnt[2:0]];
                if (r_cnt == '0) begin
                    bit_eop   = 1'b1;
                    finishing = 1'b1;
                end
            end
            default: begin
                finishing = 1'b1;
            end
        endcase
    end

    assign load   = (~r_busy | (step & finishing)) & ~i_q_empty;
    assign o_q_rd = load;

    // command sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_BYTE;
            r_cnt   <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            if (i_cmd.first && (i_cmd.pre_ones != '0)) begin
                r_phase <= PH_PRE;
                r_cnt   <= i_cmd.pre_ones - 1'b1;
            end else begin
                r_phase <= PH_BYTE;
                r_cnt   <= SEP_CNT;
            end
        end else if (step) begin
            if (finishing) begin
                r_busy <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.line_bit      <= bit_val;
            r_out.end_of_packet <= bit_eop;
        end
    end

    assign o_empty = ~r_out_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

[design/dcc_packet_bit_framer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_packet_bit_framer_core
// frames packet bytes into serial line bits with preamble and checksum
// ----------------------------------------------------------------------------
// Push packet bytes with last_byte set on the final one; pop one line bit per
// request. The serialiser produces one line bit per clock unless stalled;
// a normal byte gives 9 line bits (separator and data), the first byte of a
// packet preamble_ones more and the last byte 9 more for its checksum. Up to
// four classified bytes wait in the command queue, so pushes are taken at one
// per cycle until it fills. preamble_ones (reset 16) is written through the
// always-ready cfg channel; users must do so between packets (not enforced).
module dcc_packet_bit_framer_core import dpbf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire t_in_item         i_item,
    output logic                  empty,
    input  wire logic             pop,
    output t_out_item             o_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [PRE_W-1:0] i_cfg_data
);

    logic accept;
    logic q_full;
    logic q_empty;
    logic q_rd;
    t_cmd wr_cmd;
    t_cmd rd_cmd;

    assign full        = q_full;
    assign accept      = push & ~q_full;
    assign o_cfg_ready = 1'b1;

    // byte classification and checksum
    dpbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd       (wr_cmd)
    );

    // command queue
    dpbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept),
        .i_wr_cmd (wr_cmd),
        .i_rd     (q_rd),
        .o_rd_cmd (rd_cmd),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    // bit serialiser
    dpbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (rd_cmd),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_item)
    );

endmodule
`default_nettype wire
